>>> design/cc20_pkg.sv
// ----------------------------------------------------------------------------
// cc20_pkg
// Shared constants and types for the ChaCha20 stream cipher unit.
// ----------------------------------------------------------------------------
`default_nettype none
package cc20_pkg;

  localparam int RoundsDef = 20;
  localparam int NumWords  = 16;
  localparam int CfgAddrW  = 3;
  localparam int CfgDataW  = 64;

  localparam logic [31:0] SIGMA0 = 32'h61707865;
  localparam logic [31:0] SIGMA1 = 32'h3320646E;
  localparam logic [31:0] SIGMA2 = 32'h79622D32;
  localparam logic [31:0] SIGMA3 = 32'h6B206574;

  typedef enum logic [CfgAddrW-1:0] {
    REG_KEY_0         = 3'd0,
    REG_KEY_1         = 3'd1,
    REG_KEY_2         = 3'd2,
    REG_KEY_3         = 3'd3,
    REG_NONCE_LOW     = 3'd4,
    REG_NONCE_HIGH    = 3'd5,
    REG_COUNTER_START = 3'd6
  } cfg_reg_t;

  typedef logic [NumWords-1:0][31:0] block_t;

  typedef struct packed {
    logic start;
    logic abort;
  } core_ctl_t;

  typedef struct packed {
    logic busy;
    logic done;
  } core_sts_t;

endpackage
`default_nettype wire

>>> design/chacha20_stream_cipher_unit.sv
// ----------------------------------------------------------------------------
// chacha20_stream_cipher_unit
// ChaCha20 stream cipher: XORs message words with the keystream.
// ----------------------------------------------------------------------------
// A word of up to four bytes is taken each cycle while keystream is on hand
// and the output register has room; the result appears in an output register
// in the next cycle. Keystream blocks come from a block engine that runs one
// round per cycle with four quarter-round lanes, building one 64-byte block
// at a time; a two-block buffer lets the next block be built while the
// current one is consumed. A new build starts only in the cycle after the
// spare block has moved up, so keystream generation bounds sustained
// throughput. After reset, a configuration write or a message end the first
// word waits for a fresh block. Any configuration write to addresses 0 to 6
// reloads the block counter and discards buffered keystream.
`default_nettype none
module chacha20_stream_cipher_unit #(
  parameter int ROUNDS = cc20_pkg::RoundsDef
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          cfg_we,
  input  wire logic [cc20_pkg::CfgAddrW-1:0] cfg_addr,
  input  wire logic [cc20_pkg::CfgDataW-1:0] cfg_wdata,
  input  wire logic                          in_tvalid,
  output logic                               in_tready,
  input  wire logic [31:0]                   in_tdata,  // data_word
  input  wire logic [2:0]                    in_tuser,  // byte_count
  input  wire logic                          in_tlast,  // message_end
  output logic                               out_tvalid,
  input  wire logic                          out_tready,
  output logic      [31:0]                   out_tdata, // cipher_word
  output logic      [2:0]                    out_tuser, // out_byte_count
  output logic                               out_tlast  // out_message_end
);

  logic [255:0] key_r;
  logic [95:0]  nonce_r;
  logic [31:0]  ctr_start_r, ctr_r;

  cc20_pkg::block_t    blk_a_r, blk_b_r, gen_blk;
  logic                va_r, vb_r;
  logic [5:0]          pos_r;
  cc20_pkg::core_ctl_t ctl;
  cc20_pkg::core_sts_t sts;

  logic        out_valid_r;
  logic [31:0] out_data_r, cword;
  logic [2:0]  out_cnt_r, cnt;
  logic        out_last_r;
  logic        room, accept, cfg_hit;
  logic [6:0]  newpos, idx;
  logic [1023:0] ks_all;

  assign cfg_hit = cfg_we && (cfg_addr <= cc20_pkg::REG_COUNTER_START);

  assign ctl.abort = cfg_hit;
  assign ctl.start = !cfg_hit && !sts.busy && !vb_r;

  cc20_core #(.ROUNDS(ROUNDS)) u_core (
    .clk    (clk),
    .rst_n  (rst_n),
    .ctl    (ctl),
    .key    (key_r),
    .nonce  (nonce_r),
    .counter(ctr_r),
    .sts    (sts),
    .blk    (gen_blk)
  );

  assign room      = !out_valid_r || out_tready;
  assign in_tready = room && va_r && ((pos_r <= 6'd60) || vb_r);
  assign accept    = in_tvalid && in_tready;

  assign cnt    = (in_tuser > 3'd4) ? 3'd4 : in_tuser;
  assign newpos = {1'b0, pos_r} + {4'b0, cnt};
  assign ks_all = {blk_b_r, blk_a_r};

  always_comb begin
    cword = '0;
    idx   = '0;
    for (int i = 0; i < 4; i++) begin
      idx = {1'b0, pos_r} + 7'(i);
      if (3'(i) < cnt) begin
        cword[8*i +: 8] = in_tdata[8*i +: 8] ^ ks_all[{idx, 3'b000} +: 8];
      end
    end
  end

  // configuration registers and block counter
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      key_r       <= '0;
      nonce_r     <= '0;
      ctr_start_r <= 32'd1;
      ctr_r       <= 32'd1;
    end else if (cfg_hit) begin
      unique case (cfg_addr)
        cc20_pkg::REG_KEY_0:      key_r[63:0]    <= cfg_wdata;
        cc20_pkg::REG_KEY_1:      key_r[127:64]  <= cfg_wdata;
        cc20_pkg::REG_KEY_2:      key_r[191:128] <= cfg_wdata;
        cc20_pkg::REG_KEY_3:      key_r[255:192] <= cfg_wdata;
        cc20_pkg::REG_NONCE_LOW:  nonce_r[63:0]  <= cfg_wdata;
        cc20_pkg::REG_NONCE_HIGH: nonce_r[95:64] <= cfg_wdata[31:0];
        cc20_pkg::REG_COUNTER_START: ctr_start_r <= cfg_wdata[31:0];
        default: ;
      endcase
      ctr_r <= (cfg_addr == cc20_pkg::REG_COUNTER_START) ?
               cfg_wdata[31:0] : ctr_start_r;
    end else if (ctl.start) begin
      ctr_r <= ctr_r + 32'd1;
    end
  end

  // keystream buffer: A is current block, B the next one
  always_ff @(posedge clk) begin
    if (!rst_n || cfg_hit) begin
      va_r  <= 1'b0;
      vb_r  <= 1'b0;
      pos_r <= '0;
    end else begin
      if (accept) begin
        if (newpos < 7'd64) begin
          // an untouched block stays for the next message
          if (in_tlast && (newpos != 7'd0)) begin
            va_r  <= 1'b0;
            pos_r <= '0;
          end else begin
            pos_r <= newpos[5:0];
          end
        end else if (newpos == 7'd64) begin
          va_r  <= 1'b0;
          pos_r <= '0;
        end else begin
          blk_a_r <= blk_b_r;
          vb_r    <= 1'b0;
          va_r    <= !in_tlast;
          pos_r   <= in_tlast ? 6'd0 : newpos[5:0];
        end
      end else if (!va_r && vb_r) begin
        blk_a_r <= blk_b_r;
        va_r    <= 1'b1;
        vb_r    <= 1'b0;
        pos_r   <= '0;
      end
      if (sts.done) begin
        blk_b_r <= gen_blk;
        vb_r    <= 1'b1;
      end
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (accept) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
    if (accept) begin
      out_data_r <= cword;
      out_cnt_r  <= cnt;
      out_last_r <= in_tlast;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_cnt_r;
  assign out_tlast  = out_last_r;

endmodule
`default_nettype wire

>>> design/cc20_qr.sv
// ----------------------------------------------------------------------------
// cc20_qr
// One ChaCha quarter-round lane on four 32-bit words.
// ----------------------------------------------------------------------------
`default_nettype none
module cc20_qr (
  input  wire logic [31:0] a_in,
  input  wire logic [31:0] b_in,
  input  wire logic [31:0] c_in,
  input  wire logic [31:0] d_in,
  output logic      [31:0] a_out,
  output logic      [31:0] b_out,
  output logic      [31:0] c_out,
  output logic      [31:0] d_out
);

  logic [31:0] a1, b1, c1, d1, a2, b2, c2, d2, t;

  always_comb begin
    a1 = a_in + b_in;
    t  = d_in ^ a1;
    d1 = {t[15:0], t[31:16]};
    c1 = c_in + d1;
    t  = b_in ^ c1;
    b1 = {t[19:0], t[31:20]};
    a2 = a1 + b1;
    t  = d1 ^ a2;
    d2 = {t[23:0], t[31:24]};
    c2 = c1 + d2;
    t  = b1 ^ c2;
    b2 = {t[24:0], t[31:25]};
  end

  assign a_out = a2;
  assign b_out = b2;
  assign c_out = c2;
  assign d_out = d2;

endmodule
`default_nettype wire

>>> design/cc20_core.sv
// ----------------------------------------------------------------------------
// cc20_core
// Block function: four quarter-round lanes, one round per cycle, then the
// feed-forward add merges the working state with the initial words.
// ----------------------------------------------------------------------------
`default_nettype none
module cc20_core #(
  parameter int ROUNDS = cc20_pkg::RoundsDef
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire cc20_pkg::core_ctl_t ctl,
  input  wire logic [255:0]        key,
  input  wire logic [95:0]         nonce,
  input  wire logic [31:0]         counter,
  output cc20_pkg::core_sts_t      sts,
  output cc20_pkg::block_t         blk
);

  localparam int RndW = $clog2(ROUNDS + 1);

  cc20_pkg::block_t st_r, st_nxt, init_w, rnd_out;
  logic [31:0]      ctr_r;
  logic [RndW-1:0]  rnd_r;
  logic             busy_r;
  logic             col;
  logic [3:0][31:0] la, lb, lc, ld, oa, ob, oc, od;

  always_comb begin
    init_w[0]  = cc20_pkg::SIGMA0;
    init_w[1]  = cc20_pkg::SIGMA1;
    init_w[2]  = cc20_pkg::SIGMA2;
    init_w[3]  = cc20_pkg::SIGMA3;
    for (int i = 0; i < 8; i++) begin
      init_w[4+i] = key[32*i +: 32];
    end
    init_w[12] = ctr_r;
    init_w[13] = nonce[31:0];
    init_w[14] = nonce[63:32];
    init_w[15] = nonce[95:64];
  end

  assign col = ~rnd_r[0];

  always_comb begin
    for (int q = 0; q < 4; q++) begin
      la[q] = st_r[q];
      lb[q] = col ? st_r[4+q]  : st_r[4+((q+1)%4)];
      lc[q] = col ? st_r[8+q]  : st_r[8+((q+2)%4)];
      ld[q] = col ? st_r[12+q] : st_r[12+((q+3)%4)];
    end
  end

  for (genvar g = 0; g < 4; g++) begin : g_lane
    cc20_qr u_qr (
      .a_in (la[g]), .b_in (lb[g]), .c_in (lc[g]), .d_in (ld[g]),
      .a_out(oa[g]), .b_out(ob[g]), .c_out(oc[g]), .d_out(od[g])
    );
  end

  always_comb begin
    for (int q = 0; q < 4; q++) begin
      rnd_out[q] = oa[q];
      if (col) begin
        rnd_out[4+q]  = ob[q];
        rnd_out[8+q]  = oc[q];
        rnd_out[12+q] = od[q];
      end else begin
        rnd_out[4+((q+1)%4)]  = ob[q];
        rnd_out[8+((q+2)%4)]  = oc[q];
        rnd_out[12+((q+3)%4)] = od[q];
      end
    end
  end

  // initial words rebuilt from the live counter on start
  always_comb begin
    st_nxt = rnd_out;
    if (ctl.start) begin
      st_nxt     = init_w;
      st_nxt[12] = counter;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.start || busy_r) begin
      st_r <= st_nxt;
    end
    if (ctl.start) begin
      ctr_r <= counter;
    end
    if (!rst_n || ctl.abort) begin
      busy_r <= 1'b0;
      rnd_r  <= '0;
    end else if (ctl.start) begin
      busy_r <= 1'b1;
      rnd_r  <= '0;
    end else if (busy_r) begin
      if (rnd_r == RndW'(ROUNDS)) begin
        busy_r <= 1'b0;
      end else begin
        rnd_r <= rnd_r + RndW'(1);
      end
    end
  end

  always_comb begin
    for (int i = 0; i < cc20_pkg::NumWords; i++) begin
      blk[i] = st_r[i] + init_w[i];
    end
  end

  assign sts.busy = busy_r;
  assign sts.done = busy_r && (rnd_r == RndW'(ROUNDS)) && !ctl.abort;

endmodule
`default_nettype wire

>>> test/tb_chacha20_stream_cipher_unit.sv
// ----------------------------------------------------------------------------
// tb_chacha20_stream_cipher_unit
// Drives message words through the ChaCha20 cipher unit under several key,
// nonce and counter settings and compares each output word with a
// behavioral keystream model kept in a scoreboard class.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps
module tb_chacha20_stream_cipher_unit;

  typedef struct packed {
    logic [31:0] data;
    logic [2:0]  cnt;
    logic        last;
  } cword_t;

  class cipher_scoreboard;
    logic [63:0] key [4];
    logic [63:0] nlo;
    logic [31:0] nhi, cstart, blk_ctr;
    logic [31:0] ks [16];
    int unsigned pos;
    bit          ks_ok;
    cword_t      pending [$];
    int          errors;

    function new();
      foreach (key[i]) key[i] = '0;
      nlo = '0; nhi = '0; cstart = 32'd1; blk_ctr = 32'd1;
      pos = 0; ks_ok = 0; errors = 0;
    endfunction

    function void write_reg(cc20_pkg::cfg_reg_t idx, logic [63:0] v);
      case (idx)
        cc20_pkg::REG_KEY_0:         key[0] = v;
        cc20_pkg::REG_KEY_1:         key[1] = v;
        cc20_pkg::REG_KEY_2:         key[2] = v;
        cc20_pkg::REG_KEY_3:         key[3] = v;
        cc20_pkg::REG_NONCE_LOW:     nlo = v;
        cc20_pkg::REG_NONCE_HIGH:    nhi = v[31:0];
        cc20_pkg::REG_COUNTER_START: cstart = v[31:0];
        default: return;
      endcase
      blk_ctr = cstart; pos = 0; ks_ok = 0;
    endfunction

    function logic [31:0] rol(logic [31:0] v, int n);
      return (v << n) | (v >> (32 - n));
    endfunction

    function void qr(ref logic [31:0] w [16], input int a, b, c, d);
      w[a] += w[b]; w[d] = rol(w[d] ^ w[a], 16);
      w[c] += w[d]; w[b] = rol(w[b] ^ w[c], 12);
      w[a] += w[b]; w[d] = rol(w[d] ^ w[a], 8);
      w[c] += w[d]; w[b] = rol(w[b] ^ w[c], 7);
    endfunction

    function void gen_block();
      logic [31:0] init [16];
      logic [31:0] w [16];
      init[0] = cc20_pkg::SIGMA0; init[1] = cc20_pkg::SIGMA1;
      init[2] = cc20_pkg::SIGMA2; init[3] = cc20_pkg::SIGMA3;
      for (int i = 0; i < 4; i++) begin
        init[4 + 2*i] = key[i][31:0];
        init[5 + 2*i] = key[i][63:32];
      end
      init[12] = blk_ctr; init[13] = nlo[31:0]; init[14] = nlo[63:32];
      init[15] = nhi;
      w = init;
      for (int r = 0; r < 20; r++) begin
        if (r % 2 == 0) begin
          qr(w, 0, 4, 8, 12); qr(w, 1, 5, 9, 13);
          qr(w, 2, 6, 10, 14); qr(w, 3, 7, 11, 15);
        end else begin
          qr(w, 0, 5, 10, 15); qr(w, 1, 6, 11, 12);
          qr(w, 2, 7, 8, 13); qr(w, 3, 4, 9, 14);
        end
      end
      for (int i = 0; i < 16; i++) ks[i] = w[i] + init[i];
      blk_ctr += 1; pos = 0; ks_ok = 1;
    endfunction

    function void note_input(cword_t w);
      cword_t e;
      logic [7:0] kb;
      int n;
      n = (w.cnt > 4) ? 4 : w.cnt;
      e.data = '0; e.cnt = 3'(n); e.last = w.last;
      for (int i = 0; i < n; i++) begin
        if (!ks_ok) gen_block();
        kb = 8'(ks[pos / 4] >> (8 * (pos % 4)));
        e.data[8*i +: 8] = w.data[8*i +: 8] ^ kb;
        pos++;
        if (pos >= 64) begin pos = 0; ks_ok = 0; end
      end
      if (w.last) begin pos = 0; ks_ok = 0; end
      pending.push_back(e);
    endfunction

    function void check_output(cword_t got);
      cword_t e;
      if (pending.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected word %h", got);
        return;
      end
      e = pending.pop_front();
      if (got !== e) begin
        errors++;
        if (errors <= 10)
          $display("mismatch: exp data %h cnt %0d last %0d, got data %h cnt %0d last %0d",
                   e.data, e.cnt, e.last, got.data, got.cnt, got.last);
      end
    endfunction
  endclass

  logic clk = 0, rst_n = 0;
  logic cfg_we = 0;
  logic [cc20_pkg::CfgAddrW-1:0] cfg_addr = '0;
  logic [cc20_pkg::CfgDataW-1:0] cfg_wdata = '0;
  logic in_tvalid = 0, in_tlast = 0, out_tready = 0;
  logic [31:0] in_tdata = '0;
  logic [2:0] in_tuser = '0;
  wire in_tready, out_tvalid, out_tlast;
  wire [31:0] out_tdata;
  wire [2:0] out_tuser;

  int send_idle, recv_idle;
  cipher_scoreboard sb;

  chacha20_stream_cipher_unit uut (.*);

  always begin
    #10 clk = 1;
    #10 clk = 0;
  end

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready)
      sb.check_output('{out_tdata, out_tuser, out_tlast});
    out_tready <= ($urandom_range(99) >= recv_idle);
  end

  task automatic send_word(logic [31:0] d, logic [2:0] c, logic l);
    while ($urandom_range(99) < send_idle) begin
      in_tvalid <= 0;
      @(posedge clk);
    end
    in_tvalid <= 1; in_tdata <= d; in_tuser <= c; in_tlast <= l;
    do @(posedge clk); while (!in_tready);
    sb.note_input('{d, c, l});
  endtask

  task automatic drain();
    in_tvalid <= 0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  task automatic cfg_write(cc20_pkg::cfg_reg_t idx, logic [63:0] v);
    cfg_we <= 1; cfg_addr <= idx; cfg_wdata <= v;
    @(posedge clk);
    sb.write_reg(idx, v);
    cfg_we <= 0;
    @(posedge clk);
  endtask

  task automatic rand_cfg(int mode);
    logic [63:0] v;
    for (int i = 0; i < 7; i++) begin
      v = {$urandom, $urandom};
      if (mode == 1) v = '0;
      if (mode == 2) v = '1;
      cfg_write(cc20_pkg::cfg_reg_t'(3'(i)), v);
    end
  endtask

  task automatic rand_words(int n);
    logic [2:0] c;
    for (int i = 0; i < n; i++) begin
      c = ($urandom_range(9) < 7) ? 3'd4 : 3'($urandom_range(7));
      send_word($urandom, c, $urandom_range(15) == 0);
    end
  endtask

  initial begin
    #50_000_000;
    $display("tb: failure");
    $finish;
  end

  initial begin
    sb = new();
    send_idle = 34; recv_idle = 63;
    repeat (7) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);
    // reset key, then extremes of fields and straddling words
    send_word('0, 3'd4, 1'b0);
    send_word('1, 3'd4, 1'b0);
    send_word('1, 3'd0, 1'b0);
    send_word('1, 3'd7, 1'b0);
    send_word(32'h12345678, 3'd1, 1'b0);
    for (int i = 0; i < 16; i++) send_word($urandom, 3'd4, 1'b0);
    send_word($urandom, 3'd3, 1'b1);
    send_word($urandom, 3'd0, 1'b1);
    send_word($urandom, 3'd2, 1'b1);
    drain();
    cfg_write(cc20_pkg::cfg_reg_t'(3'd7), '1);
    rand_cfg(1);
    cfg_write(cc20_pkg::REG_COUNTER_START, 64'hFFFF_FFFF);
    rand_words(40);
    drain();
    rand_cfg(2);
    rand_words(40);
    drain();
    rand_cfg(0);
    rand_words(100);
    drain();
    send_idle = 63; recv_idle = 34;
    rand_cfg(0);
    rand_words(100);
    drain();
    send_idle = 0; recv_idle = 0;
    rand_cfg(0);
    rand_words(100);
    drain();
    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end
endmodule
